// ----- src/brf_pkg.sv -----
package brf_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [7:0] NEWLINE = 8'd10;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_POP   = 2'd1,
        K_LINE  = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_cmd;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

// ----- src/byte_ring_fifo_with_line_drain_core.sv -----
// byte ring fifo with line drain, 64 slots, holds up to 63 bytes
// request channel s_axis: tuser = action (0 push, 1 pop, 2 get line, 3 clear),
//   tdata = byte to push
// result channel m_axis: tdata = byte read (else zero), tlast = final result
//   of a request, tuser = ok, full, empty (flags as they stand after the result)
// a two-entry request queue feeds an execution engine that owns the pointers,
//   the byte ram and a single output register
// push, clear and failing pop or get line: the request passes the queue, then
//   the output register; one request per cycle while m_axis_tready stays high
// pop with data: the request passes the queue, the registered read of the byte
//   ram and the output register; no new request is taken until the read is done
// get line: a setup step for the first read, then one byte per cycle while
//   m_axis_tready stays high, until a newline or the fifo runs empty
// reset (synchronous, active low) empties the fifo and drops queued requests
// when m_axis_tready is low the output register holds its result, the engine
//   stalls, and s_axis_tready drops once the request queue is full
module byte_ring_fifo_with_line_drain_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // value
    input  logic [1:0] s_axis_tuser,  // action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // data
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser   // ok, full_res, empty_res
);

    logic          w_cmd_valid;
    logic          w_cmd_ready;
    brf_pkg::t_cmd w_cmd;
    logic          w_ok;
    logic          w_full;
    logic          w_empty;

    brf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    brf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_ok        (w_ok),
        .o_last      (m_axis_tlast),
        .o_full      (w_full),
        .o_empty     (w_empty)
    );

    assign m_axis_tuser = {w_empty, w_full, w_ok};

endmodule

// ----- src/brf_ram.sv -----
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/brf_front.sv -----
module brf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_value,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output brf_pkg::t_cmd   o_cmd
);

    brf_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;
    brf_pkg::t_cmd w_cmd;

    // classify the request
    always_comb begin
        w_cmd.kind  = brf_pkg::t_kind'(i_action);
        w_cmd.value = i_value;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- src/brf_back.sv -----
module brf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  brf_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_ok,
    output logic            o_last,
    output logic            o_full,
    output logic            o_empty
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state                    r_state, n_state;
    logic [brf_pkg::PTR_W-1:0] r_rd, n_rd;
    logic [brf_pkg::PTR_W-1:0] r_wr, n_wr;
    logic                      r_line, n_line;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_data, n_data;
    logic                      r_ok, n_ok;
    logic                      r_last, n_last;
    logic                      r_full, n_full;
    logic                      r_empty, n_empty;

    logic                      w_out_free;
    logic                      w_we;
    logic                      w_re;
    logic [7:0]                w_rdata;
    logic                      w_is_empty;
    logic                      w_is_full;

    brf_ram #(
        .WIDTH (8),
        .DEPTH (brf_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr),
        .i_wdata (i_cmd.value),
        .i_re    (w_re),
        .i_raddr (r_rd),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_is_empty = (r_rd == r_wr);
    assign w_is_full  = (brf_pkg::advance(r_wr) == r_rd);

    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_line      = r_line;
        n_out_valid = r_out_valid && !i_ready;
        n_data      = r_data;
        n_ok        = r_ok;
        n_last      = r_last;
        n_full      = r_full;
        n_empty     = r_empty;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_ready = 1'b1;
                    n_data      = 8'd0;
                    n_last      = 1'b1;
                    n_ok        = 1'b0;
                    case (i_cmd.kind)
                        brf_pkg::K_PUSH: begin
                            n_out_valid = 1'b1;
                            if (!w_is_full) begin
                                w_we = 1'b1;
                                n_wr = brf_pkg::advance(r_wr);
                                n_ok = 1'b1;
                            end
                        end
                        brf_pkg::K_POP, brf_pkg::K_LINE: begin
                            if (w_is_empty) begin
                                n_out_valid = 1'b1;
                            end else begin
                                w_re    = 1'b1;
                                n_rd    = brf_pkg::advance(r_rd);
                                n_line  = (i_cmd.kind == brf_pkg::K_LINE);
                                n_state = ST_READ;
                            end
                        end
                        brf_pkg::K_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_rd        = '0;
                            n_wr        = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_full  = (brf_pkg::advance(n_wr) == n_rd);
                    n_empty = (n_rd == n_wr);
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_data      = w_rdata;
                    n_ok        = 1'b1;
                    n_last      = !r_line || (w_rdata == brf_pkg::NEWLINE) || w_is_empty;
                    n_full      = w_is_full;
                    n_empty     = w_is_empty;
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // next byte of the line
                        w_re = 1'b1;
                        n_rd = brf_pkg::advance(r_rd);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd        <= '0;
            r_wr        <= '0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
        r_data  <= n_data;
        r_ok    <= n_ok;
        r_last  <= n_last;
        r_full  <= n_full;
        r_empty <= n_empty;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_data;
    assign o_ok    = r_ok;
    assign o_last  = r_last;
    assign o_full  = r_full;
    assign o_empty = r_empty;

endmodule

// ----- tb/tb.sv -----
module tb;

    localparam int RANDOM_ITEMS = 83;
    localparam int CALM_ITEMS = 40;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int TAIL_CYCLES = 16;

    typedef logic [brf_pkg::PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic [7:0] data;
        logic       ok;
        logic       last;
        logic       full;
        logic       empty;
    } t_reply;

    typedef struct packed {
        brf_pkg::t_kind kind;
        logic [7:0]     value;
        int             reps;
        logic           typed;
        t_reply         want;
    } t_row;

    localparam t_reply REPLY_NONE   = '0;
    localparam t_reply REPLY_REFUSE = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam t_reply REPLY_FIRST  = '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam t_reply REPLY_DROP   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [1:0] s_axis_tuser = brf_pkg::K_PUSH;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [2:0] m_axis_tuser;

    logic [7:0] ring_mem [brf_pkg::DEPTH];
    t_ptr       ring_rd = '0;
    t_ptr       ring_wr = '0;
    t_reply     ring_results [$];

    int  fails = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    t_row plan [25] = '{
        '{brf_pkg::K_POP,   8'h00, 1,  1'b1, REPLY_REFUSE},
        '{brf_pkg::K_LINE,  8'h00, 1,  1'b1, REPLY_REFUSE},
        '{brf_pkg::K_PUSH,  8'h00, 1,  1'b1, REPLY_FIRST},
        '{brf_pkg::K_PUSH,  8'hff, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_POP,   8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_POP,   8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h0b, 63, 1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'ha5, 1,  1'b1, REPLY_DROP},
        '{brf_pkg::K_LINE,  8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h41, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h0a, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h42, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_CLEAR, 8'h00, 1,  1'b1, REPLY_REFUSE},
        '{brf_pkg::K_POP,   8'h00, 1,  1'b1, REPLY_REFUSE},
        '{brf_pkg::K_PUSH,  8'h41, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h0a, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h42, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h0a, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_PUSH,  8'h43, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_LINE,  8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_LINE,  8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_POP,   8'h00, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_CLEAR, 8'h00, 1,  1'b1, REPLY_REFUSE},
        '{brf_pkg::K_PUSH,  8'h0a, 1,  1'b0, REPLY_NONE},
        '{brf_pkg::K_LINE,  8'h00, 1,  1'b0, REPLY_NONE}
    };

    byte_ring_fifo_with_line_drain_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_ptr ring_next(t_ptr p);
        return t_ptr'((int'(p) + 1) % brf_pkg::DEPTH);
    endfunction

    function automatic bit ring_full();
        return ring_next(ring_wr) == ring_rd;
    endfunction

    function automatic bit ring_empty();
        return ring_rd == ring_wr;
    endfunction

    function automatic void ring_emit(logic [7:0] data, logic ok, logic last);
        ring_results.push_back('{data, ok, last, ring_full(), ring_empty()});
    endfunction

    function automatic void ring_apply(brf_pkg::t_kind kind, logic [7:0] value);
        logic [7:0] b;
        bit stop;
        int n;
        case (kind)
            brf_pkg::K_PUSH: begin
                if (ring_full()) begin
                    ring_emit(8'h00, 1'b0, 1'b1);
                end else begin
                    ring_mem[ring_wr] = value;
                    ring_wr = ring_next(ring_wr);
                    ring_emit(8'h00, 1'b1, 1'b1);
                end
            end
            brf_pkg::K_POP: begin
                if (ring_empty()) begin
                    ring_emit(8'h00, 1'b0, 1'b1);
                end else begin
                    b = ring_mem[ring_rd];
                    ring_rd = ring_next(ring_rd);
                    ring_emit(b, 1'b1, 1'b1);
                end
            end
            brf_pkg::K_LINE: begin
                if (ring_empty()) begin
                    ring_emit(8'h00, 1'b0, 1'b1);
                end else begin
                    n = 0;
                    stop = 1'b0;
                    while (!stop && n < brf_pkg::DEPTH - 1) begin
                        b = ring_mem[ring_rd];
                        ring_rd = ring_next(ring_rd);
                        stop = (b == brf_pkg::NEWLINE) || ring_empty();
                        ring_emit(b, 1'b1, stop);
                        n++;
                    end
                end
            end
            default: begin
                ring_rd = '0;
                ring_wr = '0;
                ring_emit(8'h00, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_request(brf_pkg::t_kind kind, logic [7:0] value);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        ring_apply(kind, value);
        @(negedge i_clk);
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ring_results.size() == 0) begin
                $error("unexpected result: data %0h tlast %0b tuser %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fails++;
            end else begin
                want = ring_results.pop_front();
                check_field("data", want.data, m_axis_tdata);
                check_field("ok", 8'(want.ok), 8'(m_axis_tuser[0]));
                check_field("last", 8'(want.last), 8'(m_axis_tlast));
                check_field("full", 8'(want.full), 8'(m_axis_tuser[1]));
                check_field("empty", 8'(want.empty), 8'(m_axis_tuser[2]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        brf_pkg::t_kind kind;
        logic [7:0] value;
        int pick;
        int full_hits;
        bit filling;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            for (int i = 0; i < plan[r].reps; i++) begin
                send_request(plan[r].kind, plan[r].value + 8'(i));
            end
            if (plan[r].typed) begin
                void'(ring_results.pop_back());
                ring_results.push_back(plan[r].want);
            end
        end

        // alternate filling toward full and draining toward empty
        filling = 1'b1;
        full_hits = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (filling) begin
                kind = pick < 88 ? brf_pkg::K_PUSH :
                       pick < 94 ? brf_pkg::K_POP : brf_pkg::K_LINE;
            end else begin
                kind = pick < 15 ? brf_pkg::K_PUSH :
                       pick < 55 ? brf_pkg::K_POP :
                       pick < 95 ? brf_pkg::K_LINE : brf_pkg::K_CLEAR;
            end
            value = ($urandom_range(0, 5) == 0) ? brf_pkg::NEWLINE : 8'($urandom_range(0, 255));
            send_request(kind, value);
            if (filling && ring_full()) begin
                full_hits++;
                if (full_hits >= 3) begin
                    filling = 1'b0;
                    full_hits = 0;
                end
            end else if (!filling && ring_empty()) begin
                filling = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (ring_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
